FILE: design/robin_hood_hash_table_macros.svh
// Assertion macros for the Robin Hood hash table.
// No dependencies.
`ifndef ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define RHH_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RHH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/rhh_pkg.sv
// Package for the Robin Hood hash table: types, constants, key hash.
// No dependencies.
package rhh_pkg;
   localparam int TABLE_SLOTS_DEF = 256;
   localparam logic [7:0] MAX_ENTRIES_RST = 8'd192;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] key;
      logic [63:0] value;
      logic [31:0] hash;
   } cmd_type;

   function automatic logic [63:0] hash_stage1(input logic [63:0] k);
      logic [63:0] v;
      v = (~k) + (k << 18);
      v = v ^ (v >> 31);
      return v;
   endfunction

   function automatic logic [31:0] hash_stage2(input logic [63:0] v0);
      logic [63:0] v;
      logic [31:0] h;
      v = (v0 << 4) + v0 + (v0 << 2);
      v = v ^ (v >> 11);
      v = v + (v << 6);
      v = v ^ (v >> 22);
      h = v[31:0];
      if (h[31]) h = (~h) + 32'd1;
      return h;
   endfunction
endpackage

FILE: design/rhh_front.sv
// Front end: accepts requests, hashes keys over two stages, queues commands.
// Depends on rhh_pkg.
module rhh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_type,
   input  logic [63:0]      req_key,
   input  logic [63:0]      req_value,
   output logic             cmd_valid,
   output rhh_pkg::cmd_type cmd_data,
   input  logic             cmd_take
);
   import rhh_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_type_ff;
   logic [63:0] s1_key_ff, s1_value_ff, s1_mix_ff;
   cmd_type     q_mem_ff [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH)-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [$clog2(QUEUE_DEPTH):0]   cnt_ff, cnt_in;
   logic        s1_move, q_push, q_pop;
   cmd_type     new_cmd;

   assign q_pop   = cmd_take && (cnt_ff != '0);
   assign s1_move = s1_valid_ff && (cnt_ff < ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
   assign q_push  = s1_move;
   assign req_full = s1_valid_ff && !s1_move;

   always_comb begin
      new_cmd.op    = op_type'(s1_type_ff);
      new_cmd.key   = s1_key_ff;
      new_cmd.value = s1_value_ff;
      new_cmd.hash  = hash_stage2(s1_mix_ff);
      s1_valid_in   = (req_push && !req_full) ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      wr_ptr_in     = q_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in     = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in        = cnt_ff + (($clog2(QUEUE_DEPTH)+1)'(q_push))
                      - (($clog2(QUEUE_DEPTH)+1)'(q_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_push && !req_full) begin
         s1_type_ff  <= req_type;
         s1_key_ff   <= req_key;
         s1_value_ff <= req_value;
         s1_mix_ff   <= hash_stage1(req_key);
      end
      if (q_push) q_mem_ff[wr_ptr_ff] <= new_cmd;
   end

   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_mem_ff[rd_ptr_ff];
endmodule

FILE: design/rhh_back.sv
// Back end: walks the slot memory slot by slot, a read and a check per slot, for find, insert, delete.
// Depends on rhh_pkg.
module rhh_back #(
   parameter int TABLE_SLOTS = rhh_pkg::TABLE_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [7:0]       csr_data,
   input  logic             cmd_valid,
   input  rhh_pkg::cmd_type cmd_data,
   output logic             cmd_take,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic             rsp_found,
   output logic [63:0]      rsp_result_value,
   output logic             rsp_status
);
   import rhh_pkg::*;

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int CW = AW + 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_FREAD  = 8'b0000_0010,
      ST_FCHK   = 8'b0000_0100,
      ST_IREAD  = 8'b0000_1000,
      ST_ICHK   = 8'b0001_0000,
      ST_DREAD  = 8'b0010_0000,
      ST_DCHK   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [63:0] key_mem [TABLE_SLOTS];
   logic [63:0] val_mem [TABLE_SLOTS];
   logic [7:0]  pl_mem  [TABLE_SLOTS];
   logic [63:0] rd_key_ff, rd_val_ff;
   logic [7:0]  rd_pl_ff;
   logic        rd_vld_ff;
   logic [AW-1:0] idx_ff, idx_in, rd_addr;
   logic        rd_en;
   logic [CW-1:0] cnt_ff, cnt_in, steps_ff, steps_in;
   logic [7:0]  max_ff;
   cmd_type     cmd_ff;
   logic [63:0] ck_ff, ck_in, cv_ff, cv_in;
   logic [7:0]  cp_ff, cp_in;
   logic        wr_en, set_v, clr_v, clr2;
   logic [AW-1:0] wr_addr, clr2_addr;
   logic [63:0] wr_key, wr_val;
   logic [7:0]  wr_pl;
   logic        r_full_ff, r_found_ff, r_stat_ff;
   logic [63:0] r_val_ff;
   logic        r_set, r_found_in, r_stat_in;
   logic [63:0] r_val_in;
   logic        at_limit;

   assign at_limit = ({{8{1'b0}}, cnt_ff} >= {{CW{1'b0}}, max_ff}) ||
                     (cnt_ff >= CW'(TABLE_SLOTS - 1));
   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid && !r_full_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      steps_in = steps_ff;
      ck_in = ck_ff; cv_in = cv_ff; cp_in = cp_ff;
      rd_en = 1'b0; rd_addr = idx_ff;
      wr_en = 1'b0; set_v = 1'b0; clr_v = 1'b0; clr2 = 1'b0;
      wr_addr = idx_ff; clr2_addr = idx_ff;
      wr_key = ck_ff; wr_val = cv_ff; wr_pl = cp_ff;
      r_set = 1'b0; r_found_in = 1'b0; r_val_in = '0; r_stat_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               idx_in = cmd_data.hash[AW-1:0];
               steps_in = '0;
               if (cmd_data.op == OP_NOP) state_in = ST_DONE;
               else state_in = ST_FREAD;
            end
         end
         ST_FREAD: begin
            rd_en = 1'b1;
            state_in = ST_FCHK;
         end
         ST_FCHK: begin
            if (rd_vld_ff && rd_key_ff == cmd_ff.key && steps_ff < CW'(TABLE_SLOTS)) begin
               r_set = 1'b1; r_found_in = 1'b1; r_val_in = rd_val_ff;
               unique case (cmd_ff.op)
                  OP_PUT: begin
                     wr_en = 1'b1; wr_val = cmd_ff.value; wr_key = rd_key_ff;
                     wr_pl = rd_pl_ff;
                     state_in = ST_DONE;
                  end
                  OP_REMOVE: begin
                     clr_v = 1'b1;
                     cnt_in = cnt_ff - 1'b1;
                     idx_in = idx_ff + 1'b1;
                     steps_in = '0;
                     state_in = ST_DREAD;
                  end
                  default: state_in = ST_DONE;
               endcase
            end else if (!rd_vld_ff || steps_ff >= CW'(TABLE_SLOTS - 1)) begin
               r_set = 1'b1;
               if (cmd_ff.op == OP_PUT) begin
                  if (at_limit) begin
                     r_stat_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     idx_in = cmd_ff.hash[AW-1:0];
                     ck_in = cmd_ff.key; cv_in = cmd_ff.value; cp_in = '0;
                     state_in = ST_IREAD;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               steps_in = steps_ff + 1'b1;
               state_in = ST_FREAD;
            end
         end
         ST_IREAD: begin
            rd_en = 1'b1;
            state_in = ST_ICHK;
         end
         ST_ICHK: begin
            if (!rd_vld_ff) begin
               wr_en = 1'b1; set_v = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_DONE;
            end else begin
               if (cp_ff > rd_pl_ff) begin
                  wr_en = 1'b1;
                  ck_in = rd_key_ff; cv_in = rd_val_ff; cp_in = rd_pl_ff + 8'd1;
               end else begin
                  cp_in = cp_ff + 8'd1;
               end
               idx_in = idx_ff + 1'b1;
               state_in = ST_IREAD;
            end
         end
         ST_DREAD: begin
            rd_en = 1'b1;
            state_in = ST_DCHK;
         end
         ST_DCHK: begin
            if (rd_vld_ff && rd_pl_ff != 8'd0 && steps_ff < CW'(TABLE_SLOTS)) begin
               wr_en = 1'b1; set_v = 1'b1; wr_addr = idx_ff - 1'b1;
               wr_key = rd_key_ff; wr_val = rd_val_ff; wr_pl = rd_pl_ff - 8'd1;
               clr2 = 1'b1; clr2_addr = idx_ff;
               idx_in = idx_ff + 1'b1;
               steps_in = steps_ff + 1'b1;
               state_in = ST_DREAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!r_full_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         cnt_ff    <= '0;
         max_ff    <= MAX_ENTRIES_RST;
         r_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_write) max_ff <= csr_data;
         if (clr_v) valid_ff[idx_ff] <= 1'b0;
         if (clr2) valid_ff[clr2_addr] <= 1'b0;
         if (set_v) valid_ff[wr_addr] <= 1'b1;
         if (state_ff == ST_DONE && !r_full_ff) r_full_ff <= 1'b1;
         else if (rsp_pop && r_full_ff) r_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) cmd_ff <= cmd_data;
      idx_ff   <= idx_in;
      steps_ff <= steps_in;
      ck_ff <= ck_in; cv_ff <= cv_in; cp_ff <= cp_in;
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
         rd_pl_ff  <= pl_mem[rd_addr];
         rd_vld_ff <= valid_ff[rd_addr];
      end
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
         pl_mem[wr_addr]  <= wr_pl;
      end
      if (r_set) begin
         r_found_ff <= r_found_in;
         r_val_ff   <= r_val_in;
         r_stat_ff  <= r_stat_in;
      end
      if (cmd_take) begin
         r_found_ff <= 1'b0;
         r_val_ff   <= '0;
         r_stat_ff  <= 1'b0;
      end
   end

   assign rsp_empty        = !r_full_ff;
   assign rsp_found        = r_found_ff;
   assign rsp_result_value = r_val_ff;
   assign rsp_status       = r_stat_ff;
endmodule

FILE: design/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table: front end, command queue, back end.
// Depends on rhh_pkg, rhh_front, rhh_back and robin_hood_hash_table_macros.svh.
// A request is hashed in the front end, then the back end visits each slot with
// one registered memory read and one check: find probes from the home slot,
// insert walks the slots from the home slot, and remove shifts entries back
// until a slot ends the shift; then the response is posted. An unused request
// type skips the walk.
// The back end takes the next request only once the response has been popped.
// Slots are empty right after reset through per-slot valid flops.
`include "robin_hood_hash_table_macros.svh"
module robin_hood_hash_table #(
   parameter int TABLE_SLOTS = rhh_pkg::TABLE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key,
   input  logic [63:0] req_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_found,
   output logic [63:0] rsp_result_value,
   output logic        rsp_status,
   input  logic        csr_write,
   input  logic [7:0]  csr_data
);
   import rhh_pkg::*;

   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   rhh_front u_front (
      .clock, .reset, .req_push, .req_full, .req_type, .req_key, .req_value,
      .cmd_valid, .cmd_data, .cmd_take
   );

   rhh_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock, .reset, .csr_write, .csr_data, .cmd_valid, .cmd_data, .cmd_take,
      .rsp_empty, .rsp_pop, .rsp_found, .rsp_result_value, .rsp_status
   );

   `RHH_ASSERT_IMPL(a_take_valid, clock, reset, cmd_take, cmd_valid, "take without command")
   `RHH_ASSERT_IMPL(a_status_nf, clock, reset, !rsp_empty && rsp_status, !rsp_found, "refused but found")
   `RHH_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty, "response dropped")
endmodule

FILE: tb/sv/robin_hood_hash_table_test.sv
// Testbench for robin_hood_hash_table: directed, load-limit and random requests,
// checked against an in-bench model of the Robin Hood table. Depends on rhh_pkg.
`timescale 1ns / 100ps
module robin_hood_hash_table_test;
   import rhh_pkg::*;

   localparam int SLOTS = 256;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic        found;
      logic [63:0] value;
      logic        status;
   } outcome_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   op_type      req_type = OP_NOP;
   logic [63:0] req_key = '0;
   logic [63:0] req_value = '0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic        rsp_found;
   logic [63:0] rsp_result_value;
   logic        rsp_status;
   logic        csr_write = 0;
   logic [7:0]  csr_data = '0;

   robin_hood_hash_table dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_type(req_type),
      .req_key(req_key), .req_value(req_value),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_found(rsp_found),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // table model
   logic        tbl_valid [SLOTS];
   logic [63:0] tbl_key   [SLOTS];
   logic [63:0] tbl_value [SLOTS];
   int          tbl_probe [SLOTS];
   int          tbl_count;
   int          load_limit;

   outcome_type pending_outcomes [$];
   logic [63:0] key_pool [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          steady = 0;

   function automatic int home_of(logic [63:0] k);
      logic [63:0] v;
      logic [31:0] h;
      v = (~k) + (k << 18);
      v = v ^ (v >> 31);
      v = v * 64'd21;
      v = v ^ (v >> 11);
      v = v + (v << 6);
      v = v ^ (v >> 22);
      h = v[31:0];
      if (h[31]) h = -h;
      return int'(h & (SLOTS - 1));
   endfunction

   function automatic int locate(logic [63:0] k);
      int i;
      i = home_of(k);
      for (int n = 0; n < SLOTS && tbl_valid[i]; n++) begin
         if (tbl_key[i] == k) return i;
         i = (i + 1) % SLOTS;
      end
      return -1;
   endfunction

   function automatic void place_new(logic [63:0] k, logic [63:0] v);
      int i, cp, tp;
      logic [63:0] ck, cv, tk, tv;
      i = home_of(k);
      ck = k;
      cv = v;
      cp = 0;
      for (int n = 0; n < SLOTS && tbl_valid[i]; n++) begin
         if (cp > tbl_probe[i]) begin
            tk = tbl_key[i]; tv = tbl_value[i]; tp = tbl_probe[i];
            tbl_key[i] = ck; tbl_value[i] = cv; tbl_probe[i] = cp;
            ck = tk; cv = tv; cp = tp;
         end
         i = (i + 1) % SLOTS;
         cp++;
      end
      tbl_valid[i] = 1;
      tbl_key[i] = ck;
      tbl_value[i] = cv;
      tbl_probe[i] = cp & 255;
      tbl_count++;
   endfunction

   function automatic void shift_back(int pos);
      int i, prev;
      i = (pos + 1) % SLOTS;
      tbl_valid[pos] = 0;
      for (int n = 0; n < SLOTS && tbl_valid[i] && tbl_probe[i] > 0; n++) begin
         prev = (i + SLOTS - 1) % SLOTS;
         tbl_valid[prev] = 1;
         tbl_key[prev] = tbl_key[i];
         tbl_value[prev] = tbl_value[i];
         tbl_probe[prev] = tbl_probe[i] - 1;
         tbl_valid[i] = 0;
         i = (i + 1) % SLOTS;
      end
      if (tbl_count > 0) tbl_count--;
   endfunction

   function automatic outcome_type predict_request(op_type op, logic [63:0] k, logic [63:0] v);
      outcome_type o;
      int pos;
      o = '{1'b0, 64'd0, 1'b0};
      pos = locate(k);
      case (op)
         OP_PUT: begin
            if (pos >= 0) begin
               o.found = 1; o.value = tbl_value[pos]; tbl_value[pos] = v;
            end else if (tbl_count >= load_limit || tbl_count >= SLOTS - 1) begin
               o.status = 1;
            end else begin
               place_new(k, v);
            end
         end
         OP_GET: begin
            if (pos >= 0) begin
               o.found = 1; o.value = tbl_value[pos];
            end
         end
         OP_REMOVE: begin
            if (pos >= 0) begin
               o.found = 1; o.value = tbl_value[pos]; shift_back(pos);
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      if (steady || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(op_type op, logic [63:0] k, logic [63:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push = 0;
         repeat (gap) @(negedge clock);
      end
      req_type = op;
      req_key = k;
      req_value = v;
      req_push = 1;
      do @(posedge clock); while (req_full);
      pending_outcomes.push_back(predict_request(op, k, v));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push = 0;
      while (pending_outcomes.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_load_limit(logic [7:0] lim);
      wait_drained();
      csr_data = lim;
      csr_write = 1;
      @(negedge clock);
      csr_write = 0;
      load_limit = lim;
   endtask

   // result side: random stalls on pop
   always @(negedge clock) begin
      if (steady || $urandom_range(0, 9) < 6) rsp_pop <= 1;
      else if ($urandom_range(0, 19) == 0) rsp_pop <= 0;
      else rsp_pop <= $urandom_range(0, 1);
   end

   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected response");
            error_count++;
         end else begin
            exp_o = pending_outcomes.pop_front();
            if (rsp_found !== exp_o.found) begin
               $error("found: expected %0d actual %0d", exp_o.found, rsp_found);
               error_count++;
            end
            if (rsp_result_value !== exp_o.value) begin
               $error("result_value: expected %h actual %h", exp_o.value, rsp_result_value);
               error_count++;
            end
            if (rsp_status !== exp_o.status) begin
               $error("status: expected %0d actual %0d", exp_o.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      logic [63:0] k;
      send_request(OP_GET, 64'd0, 64'd0);
      send_request(OP_PUT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      send_request(OP_GET, 64'd0, 64'd5);
      send_request(OP_PUT, 64'd0, 64'h1234_5678_9ABC_DEF0);
      send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      send_request(OP_NOP, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_REMOVE, 64'd0, 64'd0);
      send_request(OP_REMOVE, 64'd0, 64'd0);
      send_request(OP_GET, 64'd0, 64'd0);
      send_request(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      for (int i = 0; i < 12; i++) begin
         k = rand64();
         key_pool.push_back(k);
         send_request(OP_PUT, k, rand64());
      end
   endtask

   task automatic test_load_limit(logic [7:0] lim);
      logic [63:0] fill [$];
      logic [63:0] k;
      set_load_limit(lim);
      for (int i = 0; i < int'(lim) + 4; i++) begin
         k = rand64();
         fill.push_back(k);
         send_request(OP_PUT, k, rand64());
      end
      send_request(OP_PUT, fill[0], rand64());
      if (lim > 20) begin
         wait_drained();
         steady = 1;
      end
      foreach (fill[i]) send_request(i % 3 == 0 ? OP_GET : OP_REMOVE, fill[i], '0);
      steady = 0;
      foreach (fill[i]) send_request(OP_REMOVE, fill[i], '0);
   endtask

   task automatic test_random(int n_items, logic [7:0] lim);
      logic [63:0] k;
      op_type op;
      set_load_limit(lim);
      for (int i = 0; i < n_items; i++) begin
         if (i % 200 == 100) steady = !steady;
         if (i == n_items / 2) wait_drained();
         if (key_pool.size() < 8 || $urandom_range(0, 9) < 3) begin
            k = rand64();
            if (key_pool.size() < 120) key_pool.push_back(k);
         end else begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end
         case ($urandom_range(0, 19))
            0: op = OP_NOP;
            1, 2, 3, 4, 5, 6, 7, 8: op = OP_PUT;
            9, 10, 11, 12, 13: op = OP_GET;
            default: op = OP_REMOVE;
         endcase
         send_request(op, k, rand64());
      end
      steady = 0;
   endtask

   initial begin
      foreach (tbl_valid[i]) begin
         tbl_valid[i] = 0; tbl_key[i] = '0; tbl_value[i] = '0; tbl_probe[i] = 0;
      end
      tbl_count = 0;
      load_limit = MAX_ENTRIES_RST;
      repeat (5) @(negedge clock);
      reset = 0;
      test_directed();
      test_load_limit(8'd1);
      test_load_limit(8'd255);
      test_random(250, 8'd40);
      test_random(450, 8'd8);
      test_random(250, 8'd192);
      wait_drained();
      repeat (50) @(negedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
